// ===== design/sts_pkg.sv =====
// Shared types, token kinds and character codes for the source token scanner.
`default_nettype none
package sts_pkg;

   localparam longint unsigned STS_MAX_SOURCE_BYTES = 64'd1048576;
   localparam int unsigned     STS_QUEUE_DEPTH      = 4;
   localparam int unsigned     STS_MAX_TOKENS       = 4;
   localparam logic [20:0]     STS_FIELD_MAX        = 21'h1FFFFF;

   localparam logic [4:0] KIND_DOT        = 5'd5;
   localparam logic [4:0] KIND_BANG       = 5'd10;
   localparam logic [4:0] KIND_SLASH      = 5'd18;
   localparam logic [4:0] KIND_STRING     = 5'd19;
   localparam logic [4:0] KIND_NUMBER     = 5'd20;
   localparam logic [4:0] KIND_END        = 5'd21;
   localparam logic [4:0] KIND_UNTERM     = 5'd22;
   localparam logic [4:0] KIND_UNEXPECTED = 5'd23;

   localparam logic [7:0] CH_EQ      = 8'h3D;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_LESS    = 8'h3C;
   localparam logic [7:0] CH_GREATER = 8'h3E;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

   typedef struct packed {
      logic [7:0] ch;
      logic       char_valid;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [20:0] token_start;
      logic [20:0] token_length;
      logic [20:0] line_number;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [20:0] start;
      logic [20:0] length;
      logic [20:0] line;
   } tok_type;

   typedef struct packed {
      tok_type [STS_MAX_TOKENS-1:0] toks;
      logic [1:0]                   last_idx;
   } bundle_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

endpackage
`default_nettype wire

// ===== design/sts_front.sv =====
// Scanner front: accepts bytes, tracks scan state and builds the token group of each item.
`default_nettype none
module sts_front #(
   parameter longint unsigned MAX_SOURCE_BYTES = sts_pkg::STS_MAX_SOURCE_BYTES
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire sts_pkg::req_type   req_data,
   output logic                    group_valid,
   output sts_pkg::bundle_type     group_data
);
   import sts_pkg::*;

   localparam logic [20:0] POS_CAP = (MAX_SOURCE_BYTES < 64'(STS_FIELD_MAX)) ?
                                     21'(MAX_SOURCE_BYTES) : STS_FIELD_MAX;

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_OP      = 3'd1;
   localparam logic [2:0] MODE_SLASH   = 3'd2;
   localparam logic [2:0] MODE_COMMENT = 3'd3;
   localparam logic [2:0] MODE_STRING  = 3'd4;
   localparam logic [2:0] MODE_INT     = 3'd5;
   localparam logic [2:0] MODE_DOT     = 3'd6;
   localparam logic [2:0] MODE_FRAC    = 3'd7;

   logic [2:0]  mode_ff, mode_in;
   logic [1:0]  op_ff, op_in;
   logic [20:0] tb_ff, tb_in;
   logic [20:0] bp_ff, bp_in;
   logic [20:0] lc_ff, lc_in;

   tok_type [STS_MAX_TOKENS-1:0] toks;
   logic [2:0]  n;
   logic        fresh;
   logic        is_dig;
   logic [4:0]  pk;
   logic        pk_hit;
   logic [7:0]  c;
   logic [20:0] dot_pos;

   function automatic logic [20:0] span(input logic [20:0] e, input logic [20:0] b);
      span = (e > b) ? (e - b) : 21'd0;
   endfunction

   function automatic logic [20:0] span_plus(input logic [20:0] e, input logic [20:0] b);
      logic [21:0] s;
      s = {1'b0, span(e, b)} + 22'd1;
      span_plus = s[21] ? STS_FIELD_MAX : s[20:0];
   endfunction

   function automatic logic [20:0] line_inc(input logic [20:0] l);
      line_inc = (l != STS_FIELD_MAX) ? (l + 21'd1) : l;
   endfunction

   function automatic tok_type make_tok(input logic [4:0] k, input logic [20:0] s,
                                        input logic [20:0] len, input logic [20:0] l);
      make_tok = '{kind: k, start: s, length: len, line: l};
   endfunction

   always_comb begin
      pk_hit = 1'b1;
      unique case (c)
         8'h28:   pk = 5'd0;
         8'h29:   pk = 5'd1;
         8'h7B:   pk = 5'd2;
         8'h7D:   pk = 5'd3;
         8'h2C:   pk = 5'd4;
         CH_DOT:  pk = KIND_DOT;
         8'h2D:   pk = 5'd6;
         8'h2B:   pk = 5'd7;
         8'h3B:   pk = 5'd8;
         8'h2A:   pk = 5'd9;
         default: begin
            pk     = 5'd0;
            pk_hit = 1'b0;
         end
      endcase
   end

   assign c      = req_data.ch;
   assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);

   always_comb begin
      mode_in = mode_ff;
      op_in   = op_ff;
      tb_in   = tb_ff;
      bp_in   = bp_ff;
      lc_in   = lc_ff;
      toks    = '0;
      n       = 3'd0;
      fresh   = 1'b0;
      dot_pos = 21'd0;

      if (accept && req_data.char_valid) begin
         unique case (mode_ff)
            MODE_OP: begin
               if (c == CH_EQ) begin
                  toks[n[1:0]] = make_tok(KIND_BANG + {2'b00, op_ff, 1'b1}, tb_ff,
                                          span_plus(bp_ff, tb_ff), lc_in);
                  n       = n + 3'd1;
                  mode_in = MODE_IDLE;
               end else begin
                  toks[n[1:0]] = make_tok(KIND_BANG + {2'b00, op_ff, 1'b0}, tb_ff,
                                          21'd1, lc_in);
                  n     = n + 3'd1;
                  fresh = 1'b1;
               end
            end
            MODE_SLASH: begin
               if (c == CH_SLASH) begin
                  mode_in = MODE_COMMENT;
               end else begin
                  toks[n[1:0]] = make_tok(KIND_SLASH, tb_ff, 21'd1, lc_in);
                  n     = n + 3'd1;
                  fresh = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (c == CH_NEWLINE) begin
                  fresh = 1'b1;
               end
            end
            MODE_STRING: begin
               if (c == CH_QUOTE) begin
                  toks[n[1:0]] = make_tok(KIND_STRING, tb_ff, span_plus(bp_ff, tb_ff), lc_in);
                  n       = n + 3'd1;
                  mode_in = MODE_IDLE;
               end else if (c == CH_NEWLINE) begin
                  lc_in = line_inc(lc_in);
               end
            end
            MODE_INT: begin
               if (c == CH_DOT) begin
                  mode_in = MODE_DOT;
               end else if (!is_dig) begin
                  toks[n[1:0]] = make_tok(KIND_NUMBER, tb_ff, span(bp_ff, tb_ff), lc_in);
                  n     = n + 3'd1;
                  fresh = 1'b1;
               end
            end
            MODE_DOT: begin
               if (is_dig) begin
                  mode_in = MODE_FRAC;
               end else begin
                  dot_pos = (bp_ff > tb_ff) ? (bp_ff - 21'd1) : tb_ff;
                  toks[n[1:0]] = make_tok(KIND_NUMBER, tb_ff, span(dot_pos, tb_ff), lc_in);
                  n = n + 3'd1;
                  toks[n[1:0]] = make_tok(KIND_DOT, dot_pos, 21'd1, lc_in);
                  n     = n + 3'd1;
                  fresh = 1'b1;
               end
            end
            MODE_FRAC: begin
               if (!is_dig) begin
                  toks[n[1:0]] = make_tok(KIND_NUMBER, tb_ff, span(bp_ff, tb_ff), lc_in);
                  n     = n + 3'd1;
                  fresh = 1'b1;
               end
            end
            default: begin
               fresh = 1'b1;
            end
         endcase

         if (fresh) begin
            mode_in = MODE_IDLE;
            tb_in   = bp_ff;
            if (pk_hit) begin
               toks[n[1:0]] = make_tok(pk, bp_ff, 21'd1, lc_in);
               n = n + 3'd1;
            end else if (c == CH_BANG) begin
               op_in   = 2'd0;
               mode_in = MODE_OP;
            end else if (c == CH_EQ) begin
               op_in   = 2'd1;
               mode_in = MODE_OP;
            end else if (c == CH_LESS) begin
               op_in   = 2'd2;
               mode_in = MODE_OP;
            end else if (c == CH_GREATER) begin
               op_in   = 2'd3;
               mode_in = MODE_OP;
            end else if (c == CH_SLASH) begin
               mode_in = MODE_SLASH;
            end else if (c == CH_SPACE || c == CH_CR || c == CH_TAB) begin
               mode_in = MODE_IDLE;
            end else if (c == CH_NEWLINE) begin
               lc_in = line_inc(lc_in);
            end else if (c == CH_QUOTE) begin
               mode_in = MODE_STRING;
            end else if (is_dig) begin
               mode_in = MODE_INT;
            end else begin
               toks[n[1:0]] = make_tok(KIND_UNEXPECTED, bp_ff, 21'd1, lc_in);
               n = n + 3'd1;
            end
         end

         if (bp_ff < POS_CAP) begin
            bp_in = bp_ff + 21'd1;
         end
      end

      if (accept && req_data.end_of_source) begin
         unique case (mode_in)
            MODE_OP: begin
               toks[n[1:0]] = make_tok(KIND_BANG + {2'b00, op_in, 1'b0}, tb_in, 21'd1, lc_in);
               n = n + 3'd1;
            end
            MODE_SLASH: begin
               toks[n[1:0]] = make_tok(KIND_SLASH, tb_in, 21'd1, lc_in);
               n = n + 3'd1;
            end
            MODE_STRING: begin
               toks[n[1:0]] = make_tok(KIND_UNTERM, tb_in, span(bp_in, tb_in), lc_in);
               n = n + 3'd1;
            end
            MODE_INT, MODE_FRAC: begin
               toks[n[1:0]] = make_tok(KIND_NUMBER, tb_in, span(bp_in, tb_in), lc_in);
               n = n + 3'd1;
            end
            MODE_DOT: begin
               dot_pos = (bp_in > tb_in) ? (bp_in - 21'd1) : tb_in;
               toks[n[1:0]] = make_tok(KIND_NUMBER, tb_in, span(dot_pos, tb_in), lc_in);
               n = n + 3'd1;
               toks[n[1:0]] = make_tok(KIND_DOT, dot_pos, 21'd1, lc_in);
               n = n + 3'd1;
            end
            default: begin
               n = n;
            end
         endcase
         toks[n[1:0]] = make_tok(KIND_END, bp_in, 21'd0, lc_in);
         n = n + 3'd1;

         mode_in = MODE_IDLE;
         op_in   = 2'd0;
         tb_in   = 21'd0;
         bp_in   = 21'd0;
         lc_in   = 21'd1;
      end
   end

   assign group_valid         = (n != 3'd0);
   assign group_data.toks     = toks;
   assign group_data.last_idx = n[1:0] - 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         op_ff   <= 2'd0;
         tb_ff   <= 21'd0;
         bp_ff   <= 21'd0;
         lc_ff   <= 21'd1;
      end else begin
         mode_ff <= mode_in;
         op_ff   <= op_in;
         tb_ff   <= tb_in;
         bp_ff   <= bp_in;
         lc_ff   <= lc_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/sts_queue.sv =====
// Short queue of token groups between the scanner front and the result back.
`default_nettype none
module sts_queue #(
   parameter int unsigned DEPTH = sts_pkg::STS_QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire sts_pkg::bundle_type  wr_data,
   input  wire logic                 rd_en,
   output sts_pkg::bundle_type       rd_data,
   output sts_pkg::qstat_type        status
);
   import sts_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   bundle_type       mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             do_wr, do_rd;

   assign status.empty = (cnt_ff == '0);
   assign status.full  = (cnt_ff == (AW+1)'(DEPTH));
   assign do_wr        = wr_en && !status.full;
   assign do_rd        = rd_en && !status.empty;
   assign rd_data      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      unique case ({do_wr, do_rd})
         2'b10:   cnt_in = cnt_ff + (AW+1)'(1);
         2'b01:   cnt_in = cnt_ff - (AW+1)'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/sts_back.sv =====
// Result back: walks the head token group and hands out one token per pop.
`default_nettype none
module sts_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sts_pkg::bundle_type  head,
   input  wire sts_pkg::qstat_type   status,
   input  wire logic                 rsp_pop,
   output logic                      rsp_empty,
   output sts_pkg::rsp_type          rsp_data,
   output logic                      head_done
);
   import sts_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       last;
   logic       take;
   tok_type    cur;

   assign cur       = head.toks[idx_ff];
   assign last      = (idx_ff == head.last_idx);
   assign rsp_empty = status.empty;
   assign take      = rsp_pop && !status.empty;
   assign head_done = take && last;

   assign rsp_data.token_kind   = cur.kind;
   assign rsp_data.token_start  = cur.start;
   assign rsp_data.token_length = cur.length;
   assign rsp_data.line_number  = cur.line;
   assign rsp_data.last_of_run  = last;

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/source_token_scanner_core.sv =====
// Top level of the source token scanner: front scanner, group queue and result back.
// Throughput: one byte item accepted per cycle while the group queue has room.
// A taken item's tokens are registered in the group queue, behind any earlier groups.
// Popped tokens leave one per cycle; an item's up to four tokens hold one queue slot.
// Synchronous active-high reset returns the scan state to idle, line 1, offset 0
// and empties the queue; no clearing pass follows.
`default_nettype none
module source_token_scanner_core #(
   parameter longint unsigned MAX_SOURCE_BYTES = sts_pkg::STS_MAX_SOURCE_BYTES,
   parameter int unsigned     QUEUE_DEPTH      = sts_pkg::STS_QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire sts_pkg::req_type  req_data,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output sts_pkg::rsp_type       rsp_data
);
   import sts_pkg::*;

   logic       accept;
   logic       group_valid;
   bundle_type group_data;
   bundle_type head;
   qstat_type  status;
   logic       head_done;

   assign req_full = status.full;
   assign accept   = req_push && !status.full;

   sts_front #(
      .MAX_SOURCE_BYTES(MAX_SOURCE_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_data    (req_data),
      .group_valid (group_valid),
      .group_data  (group_data)
   );

   sts_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (group_valid),
      .wr_data (group_data),
      .rd_en   (head_done),
      .rd_data (head),
      .status  (status)
   );

   sts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .status    (status),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .head_done (head_done)
   );

endmodule
`default_nettype wire

// ===== bench/source_token_scanner_core_tb.sv =====
// Self-checking bench for the source token scanner: queue handshakes, token prediction.
module source_token_scanner_core_tb;
   import sts_pkg::*;

   localparam longint unsigned POS_CAP =
      (STS_MAX_SOURCE_BYTES < STS_FIELD_MAX) ? STS_MAX_SOURCE_BYTES : STS_FIELD_MAX;
   localparam int RANDOM_ITEMS = 200;

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_OP, MODE_SLASH, MODE_COMMENT,
      MODE_STRING, MODE_INT, MODE_DOT, MODE_FRAC
   } scan_mode_e;

   typedef enum logic [1:0] {OP_BANG, OP_EQUAL, OP_LESS, OP_GREATER} pending_op_e;

   class token_scoreboard;
      rsp_type           expected_tokens[$];
      rsp_type           item_tokens[$];
      int                mismatches = 0;
      scan_mode_e        mode = MODE_IDLE;
      pending_op_e       pending_op = OP_BANG;
      longint unsigned   tok_begin = 0;
      longint unsigned   byte_pos = 0;
      longint unsigned   line_cnt = 1;
      string             punct_chars = "(){},.-+;*";

      function void clear_scan();
         mode = MODE_IDLE;
         pending_op = OP_BANG;
         tok_begin = 0;
         byte_pos = 0;
         line_cnt = 1;
      endfunction

      function void emit(logic [4:0] kind, longint unsigned start, longint unsigned len);
         rsp_type tok;
         if (item_tokens.size() >= STS_MAX_TOKENS) return;
         tok.token_kind = kind;
         tok.token_start = start[20:0];
         tok.token_length = (len > STS_FIELD_MAX) ? STS_FIELD_MAX : len[20:0];
         tok.line_number = line_cnt[20:0];
         tok.last_of_run = 1'b0;
         item_tokens = {item_tokens, tok};
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= CH_ZERO && c <= CH_NINE;
      endfunction

      function longint unsigned span(longint unsigned stop_pos);
         return (stop_pos > tok_begin) ? stop_pos - tok_begin : 0;
      endfunction

      function void count_line();
         if (line_cnt < STS_FIELD_MAX) line_cnt++;
      endfunction

      function void emit_number_dot(longint unsigned stop_pos);
         longint unsigned dot_pos;
         dot_pos = (stop_pos > tok_begin) ? stop_pos - 1 : tok_begin;
         emit(KIND_NUMBER, tok_begin, span(dot_pos));
         emit(KIND_DOT, dot_pos, 1);
      endfunction

      function void scan_fresh(logic [7:0] c);
         int p;
         p = -1;
         for (int i = 0; i < punct_chars.len(); i++) begin
            if (punct_chars[i] == c) p = i;
         end
         mode = MODE_IDLE;
         tok_begin = byte_pos;
         if (p >= 0) begin
            emit(5'(p), byte_pos, 1);
            return;
         end
         case (c)
            CH_BANG: begin pending_op = OP_BANG; mode = MODE_OP; end
            CH_EQ: begin pending_op = OP_EQUAL; mode = MODE_OP; end
            CH_LESS: begin pending_op = OP_LESS; mode = MODE_OP; end
            CH_GREATER: begin pending_op = OP_GREATER; mode = MODE_OP; end
            CH_SLASH: mode = MODE_SLASH;
            CH_SPACE, CH_CR, CH_TAB: ;
            CH_NEWLINE: count_line();
            CH_QUOTE: mode = MODE_STRING;
            default: begin
               if (is_digit(c)) mode = MODE_INT;
               else emit(KIND_UNEXPECTED, byte_pos, 1);
            end
         endcase
      endfunction

      function void scan_byte(logic [7:0] c);
         case (mode)
            MODE_OP: begin
               if (c == CH_EQ) begin
                  emit(5'(KIND_BANG + 2 * pending_op + 1), tok_begin, span(byte_pos) + 1);
                  mode = MODE_IDLE;
               end else begin
                  emit(5'(KIND_BANG + 2 * pending_op), tok_begin, 1);
                  scan_fresh(c);
               end
            end
            MODE_SLASH: begin
               if (c == CH_SLASH) mode = MODE_COMMENT;
               else begin
                  emit(KIND_SLASH, tok_begin, 1);
                  scan_fresh(c);
               end
            end
            MODE_COMMENT: begin
               if (c == CH_NEWLINE) scan_fresh(c);
            end
            MODE_STRING: begin
               if (c == CH_QUOTE) begin
                  emit(KIND_STRING, tok_begin, span(byte_pos) + 1);
                  mode = MODE_IDLE;
               end else if (c == CH_NEWLINE) begin
                  count_line();
               end
            end
            MODE_INT: begin
               if (c == CH_DOT) mode = MODE_DOT;
               else if (!is_digit(c)) begin
                  emit(KIND_NUMBER, tok_begin, span(byte_pos));
                  scan_fresh(c);
               end
            end
            MODE_DOT: begin
               if (is_digit(c)) mode = MODE_FRAC;
               else begin
                  emit_number_dot(byte_pos);
                  scan_fresh(c);
               end
            end
            MODE_FRAC: begin
               if (!is_digit(c)) begin
                  emit(KIND_NUMBER, tok_begin, span(byte_pos));
                  scan_fresh(c);
               end
            end
            default: scan_fresh(c);
         endcase
      endfunction

      function void flush_source();
         case (mode)
            MODE_OP: emit(5'(KIND_BANG + 2 * pending_op), tok_begin, 1);
            MODE_SLASH: emit(KIND_SLASH, tok_begin, 1);
            MODE_STRING: emit(KIND_UNTERM, tok_begin, span(byte_pos));
            MODE_INT, MODE_FRAC: emit(KIND_NUMBER, tok_begin, span(byte_pos));
            MODE_DOT: emit_number_dot(byte_pos);
            default: ;
         endcase
         emit(KIND_END, byte_pos, 0);
      endfunction

      function void predict_tokens(req_type item);
         item_tokens.delete();
         if (item.char_valid) begin
            scan_byte(item.ch);
            if (byte_pos < POS_CAP) byte_pos++;
         end
         if (item.end_of_source) begin
            flush_source();
            clear_scan();
         end
         if (item_tokens.size() > 0) item_tokens[item_tokens.size() - 1].last_of_run = 1'b1;
         foreach (item_tokens[i]) expected_tokens = {expected_tokens, item_tokens[i]};
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= 50) $display("mismatch: %s", msg);
      endtask

      task check_token(rsp_type got);
         rsp_type want;
         string bad;
         bad = "";
         if (expected_tokens.size() == 0) begin
            report($sformatf("token kind %0d start %0d with none awaited",
                             got.token_kind, got.token_start));
            return;
         end
         want = expected_tokens.pop_front();
         if (got.token_kind !== want.token_kind) bad = {bad, " kind"};
         if (got.token_start !== want.token_start) bad = {bad, " start"};
         if (got.token_length !== want.token_length) bad = {bad, " length"};
         if (got.line_number !== want.line_number) bad = {bad, " line"};
         if (got.last_of_run !== want.last_of_run) bad = {bad, " last"};
         if (bad != "") begin
            report($sformatf("%s: got %0d/%0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d/%0d", bad,
                             got.token_kind, got.token_start, got.token_length,
                             got.line_number, got.last_of_run,
                             want.token_kind, want.token_start, want.token_length,
                             want.line_number, want.last_of_run));
         end
      endtask

      task check_leftovers();
         if (expected_tokens.size() != 0) begin
            report($sformatf("%0d tokens never arrived", expected_tokens.size()));
         end
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   token_scoreboard book = new();
   int          items_sent = 0;
   int          burst_left = 0;
   bit          random_phase = 1'b0;
   logic [7:0]  source_bytes[$];

   source_token_scanner_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function void add_byte(logic [7:0] b);
      source_bytes = {source_bytes, b};
   endfunction

   task pause_sender();
      int n;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      repeat (n) begin
         @(negedge clock);
         req_push <= 1'b0;
         req_data <= req_type'(10'($urandom));
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 8);
   endtask

   task send_item(logic [7:0] c, logic v, logic e);
      req_type item;
      item = '{ch: c, char_valid: v, end_of_source: e};
      if (burst_left == 0) pause_sender();
      @(negedge clock);
      req_data <= item;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      book.predict_tokens(item);
      if (v || e) items_sent++;
      burst_left--;
   endtask

   task send_string(string s, bit close);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b1, close && i == s.len() - 1);
   endtask

   task send_fragment();
      string       ops;
      logic [7:0]  blanks[4];
      ops = "!=<>";
      blanks = '{CH_SPACE, CH_TAB, CH_CR, CH_NEWLINE};
      source_bytes.delete();
      case ($urandom_range(0, 11))
         0, 1: add_byte(book.punct_chars[$urandom_range(0, 9)]);
         2: begin
            add_byte(ops[$urandom_range(0, 3)]);
            if ($urandom_range(0, 1)) add_byte(CH_EQ);
         end
         3: add_byte(CH_SLASH);
         4: begin
            add_byte(CH_SLASH);
            add_byte(CH_SLASH);
            repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(32, 126)));
            add_byte(CH_NEWLINE);
         end
         5: begin
            add_byte(CH_QUOTE);
            repeat ($urandom_range(0, 6)) begin
               if ($urandom_range(0, 4) == 0) add_byte(CH_NEWLINE);
               else add_byte(8'($urandom_range(32, 126)));
            end
            if ($urandom_range(0, 5) != 0) add_byte(CH_QUOTE);
         end
         6, 7: begin
            repeat ($urandom_range(1, 4)) add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
            if ($urandom_range(0, 1)) begin
               add_byte(CH_DOT);
               repeat ($urandom_range(0, 3)) add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
            end
         end
         8: add_byte(blanks[$urandom_range(0, 3)]);
         9: add_byte(8'($urandom_range(0, 255)));
         default: add_byte(8'($urandom_range(32, 126)));
      endcase
      foreach (source_bytes[i]) send_item(source_bytes[i], 1'b1, 1'b0);
   endtask

   initial begin
      int hold_left;
      int pop_style;
      int cycle;
      bit held;
      hold_left = 0;
      pop_style = 0;
      cycle = 0;
      held = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         cycle++;
         if (cycle % 50 == 0) pop_style = $urandom_range(0, 3);
         if (!held && random_phase) begin
            held = 1'b1;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            case (pop_style)
               0: rsp_pop <= 1'b1;
               1: rsp_pop <= 1'($urandom_range(0, 1));
               2: rsp_pop <= (cycle % 4 == 0);
               default: rsp_pop <= ($urandom_range(0, 7) == 0);
            endcase
         end
         @(posedge clock);
         if (rsp_pop && !rsp_empty) book.check_token(rsp_data);
      end
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int drain_cycles;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_string("1.(", 1'b0);
      send_string("!=", 1'b0);
      send_string("=", 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_string("//x\n", 1'b0);
      send_string("\"\n\"", 1'b0);
      send_string("<", 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(CH_EQ, 1'b1, 1'b1);
      send_string("9.(", 1'b1);
      send_string("\"", 1'b0);
      send_item(8'hFF, 1'b0, 1'b1);
      send_string("/>", 1'b1);
      send_item(8'h00, 1'b0, 1'b1);

      random_phase = 1'b1;
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         send_fragment();
         if ($urandom_range(0, 24) == 0) begin
            send_item(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
         end
         if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      end
      send_item(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
      @(negedge clock);
      req_push <= 1'b0;

      drain_cycles = 0;
      while (book.expected_tokens.size() != 0 && drain_cycles < 50000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (20) @(posedge clock);
      book.check_leftovers();
      if (book.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

// ===== source_token_scanner_core.f =====
design/sts_pkg.sv
design/sts_front.sv
design/sts_queue.sv
design/sts_back.sv
design/source_token_scanner_core.sv
bench/source_token_scanner_core_tb.sv
